// ----- hw/rtl/rwsp_pkg.sv -----
// Shared types and constants of the register write stream player.
package rwsp_pkg;

    typedef enum logic [1:0] {
        KIND_WRITE    = 2'd0,
        KIND_WAIT     = 2'd1,
        KIND_FINISHED = 2'd2,
        KIND_ERROR    = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       end_of_stream;
        logic       spare_empty;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [4:0]  reg_addr;
        logic [7:0]  reg_value;
        logic [13:0] wait_units;
        logic        refill_request;
    } out_item_t;

    localparam logic [7:0]  ADDR_LIMIT        = 8'h20;
    localparam logic [7:0]  CMD_WAIT          = 8'h81;
    localparam logic [7:0]  CMD_END           = 8'hFF;
    localparam logic [15:0] CREDIT_MAX        = 16'hFFFF;
    localparam logic [15:0] REFILL_COST_RESET = 16'd928;

endpackage

// ----- hw/rtl/rwsp_parser.sv -----
// Command byte parser with credit accounting and the refill cost register.
module rwsp_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic [15:0]         cfg_data,
    input  logic                step_en,
    input  rwsp_pkg::in_item_t  item,
    output logic                res_valid,
    output rwsp_pkg::out_item_t res_item
);

    typedef enum logic [1:0] {
        PH_CMD      = 2'd0,
        PH_VALUE    = 2'd1,
        PH_COUNT_LO = 2'd2,
        PH_COUNT_HI = 2'd3
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [4:0]  held_addr_reg, held_addr_next;
    logic [7:0]  count_lo_reg, count_lo_next;
    logic [15:0] credit_reg, credit_next;
    logic        halted_reg, halted_next;
    logic [15:0] cost_reg;

    logic [15:0] count;
    logic [16:0] credit_sum;
    logic [15:0] credit_sat;

    assign count      = {item.stream_byte, count_lo_reg};
    assign credit_sum = {1'b0, credit_reg} + {1'b0, count};
    assign credit_sat = (credit_sum >= {1'b0, rwsp_pkg::CREDIT_MAX}) ?
                        rwsp_pkg::CREDIT_MAX : credit_sum[15:0];

    always_comb begin
        phase_next     = phase_reg;
        held_addr_next = held_addr_reg;
        count_lo_next  = count_lo_reg;
        credit_next    = credit_reg;
        halted_next    = halted_reg;
        res_valid      = 1'b0;
        res_item       = '0;
        res_item.kind  = rwsp_pkg::KIND_WRITE;
        if (step_en && !halted_reg) begin
            if (item.end_of_stream) begin
                // drop any partial write or wait
                halted_next   = 1'b1;
                phase_next    = PH_CMD;
                res_valid     = 1'b1;
                res_item.kind = rwsp_pkg::KIND_FINISHED;
            end else begin
                case (phase_reg)
                    PH_CMD: begin
                        if (item.stream_byte < rwsp_pkg::ADDR_LIMIT) begin
                            held_addr_next = item.stream_byte[4:0];
                            phase_next     = PH_VALUE;
                        end else if (item.stream_byte == rwsp_pkg::CMD_WAIT) begin
                            phase_next = PH_COUNT_LO;
                        end else begin
                            halted_next   = 1'b1;
                            res_valid     = 1'b1;
                            res_item.kind = (item.stream_byte == rwsp_pkg::CMD_END) ?
                                            rwsp_pkg::KIND_FINISHED :
                                            rwsp_pkg::KIND_ERROR;
                        end
                    end
                    PH_VALUE: begin
                        phase_next         = PH_CMD;
                        res_valid          = 1'b1;
                        res_item.kind      = rwsp_pkg::KIND_WRITE;
                        res_item.reg_addr  = held_addr_reg;
                        res_item.reg_value = item.stream_byte;
                    end
                    PH_COUNT_LO: begin
                        count_lo_next = item.stream_byte;
                        phase_next    = PH_COUNT_HI;
                    end
                    PH_COUNT_HI: begin
                        phase_next          = PH_CMD;
                        res_valid           = 1'b1;
                        res_item.kind       = rwsp_pkg::KIND_WAIT;
                        res_item.wait_units = count[15:2];
                        if (item.spare_empty && (credit_sat >= cost_reg)) begin
                            credit_next             = credit_sat - cost_reg;
                            res_item.refill_request = 1'b1;
                        end else begin
                            credit_next = credit_sat;
                        end
                    end
                    default: begin
                        phase_next = PH_CMD;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_CMD;
            held_addr_reg <= '0;
            count_lo_reg  <= '0;
            credit_reg    <= '0;
            halted_reg    <= 1'b0;
            cost_reg      <= rwsp_pkg::REFILL_COST_RESET;
        end else begin
            phase_reg     <= phase_next;
            held_addr_reg <= held_addr_next;
            count_lo_reg  <= count_lo_next;
            credit_reg    <= credit_next;
            halted_reg    <= halted_next;
            if (cfg_valid) begin
                cost_reg <= cfg_data;
            end
        end
    end

endmodule

// ----- hw/rtl/register_write_stream_player_unit.sv -----
// Top level: input register, parser and result register of the stream player.
// Path: input register, then the single parser step, then the result register (m_valid).
// One input beat per cycle while the result register is free (empty or m_ready).
// Beats that produce no result (address, count low, anything after a stop) drop out.
// Reset (aresetn low, synchronous): both registers empty, parser idle, credit zero,
// refill cost back to 928.
module register_write_stream_player_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  rwsp_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output rwsp_pkg::out_item_t m_item
);

    logic                in_valid_reg;
    rwsp_pkg::in_item_t  in_item_reg;
    logic                out_valid_reg;
    rwsp_pkg::out_item_t out_item_reg;

    logic                out_free;
    logic                advance;
    logic                res_valid;
    rwsp_pkg::out_item_t res_item;

    assign out_free  = !out_valid_reg || m_ready;
    assign advance   = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_item    = out_item_reg;

    rwsp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .step_en   (advance),
        .item      (in_item_reg),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= advance && res_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
        if (out_free && advance && res_valid) begin
            out_item_reg <= res_item;
        end
    end

endmodule

// ----- hw/rtl/rwsp_checker.sv -----
// Port-level checks of the stream player, bound to the top level.
module rwsp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input rwsp_pkg::out_item_t m_item
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // after a finish or error beat leaves, nothing more comes out
    a_halt_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && (m_item.kind == rwsp_pkg::KIND_FINISHED ||
                               m_item.kind == rwsp_pkg::KIND_ERROR) |=> !m_valid)
        else $error("result after playback stopped");

    a_refill_on_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.refill_request |-> m_item.kind == rwsp_pkg::KIND_WAIT)
        else $error("refill request on a non-wait beat");

endmodule

bind register_write_stream_player_unit rwsp_checker u_rwsp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

// ----- tb/tb_register_write_stream_player_unit.sv -----
// Self-checking testbench for the stream player: register writes, waits, refill credit and stop.
module tb_register_write_stream_player_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT   = 500000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned PRINT_LIMIT   = 20;

    typedef enum logic [1:0] {
        PH_CMD      = 2'd0,
        PH_VALUE    = 2'd1,
        PH_COUNT_LO = 2'd2,
        PH_COUNT_HI = 2'd3
    } phase_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [15:0]         cfg_data;
    logic                s_valid;
    logic                s_ready;
    rwsp_pkg::in_item_t  s_item;
    logic                m_valid;
    logic                m_ready;
    rwsp_pkg::out_item_t m_item;

    // Player model state
    phase_t      model_phase;
    logic [4:0]  model_addr;
    logic [7:0]  model_count_lo;
    logic [15:0] model_credit;
    logic [15:0] model_cost;
    bit          model_halted;

    rwsp_pkg::out_item_t expected_events[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    bit          src_quiet   = 1'b0;
    bit          snk_quiet   = 1'b0;

    register_write_stream_player_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic rwsp_pkg::in_item_t make_item(input logic [7:0] b, input logic eos,
                                                     input logic spare);
        rwsp_pkg::in_item_t it;
        it.stream_byte   = b;
        it.end_of_stream = eos;
        it.spare_empty   = spare;
        return it;
    endfunction

    // Advance the player model by one byte; returns 1 when the byte yields an event.
    function automatic bit advance_player_model(input rwsp_pkg::in_item_t it,
                                                output rwsp_pkg::out_item_t ev);
        logic [15:0] count;
        logic [16:0] sum;
        ev = '0;
        if (model_halted)
            return 1'b0;
        if (it.end_of_stream) begin
            model_halted = 1'b1;
            model_phase  = PH_CMD;
            ev.kind      = rwsp_pkg::KIND_FINISHED;
            return 1'b1;
        end
        case (model_phase)
            PH_CMD: begin
                if (it.stream_byte < rwsp_pkg::ADDR_LIMIT) begin
                    model_addr  = it.stream_byte[4:0];
                    model_phase = PH_VALUE;
                    return 1'b0;
                end
                if (it.stream_byte == rwsp_pkg::CMD_WAIT) begin
                    model_phase = PH_COUNT_LO;
                    return 1'b0;
                end
                model_halted = 1'b1;
                ev.kind = (it.stream_byte == rwsp_pkg::CMD_END) ? rwsp_pkg::KIND_FINISHED :
                                                                  rwsp_pkg::KIND_ERROR;
                return 1'b1;
            end
            PH_VALUE: begin
                model_phase  = PH_CMD;
                ev.kind      = rwsp_pkg::KIND_WRITE;
                ev.reg_addr  = model_addr;
                ev.reg_value = it.stream_byte;
                return 1'b1;
            end
            PH_COUNT_LO: begin
                model_count_lo = it.stream_byte;
                model_phase    = PH_COUNT_HI;
                return 1'b0;
            end
            default: begin
                count        = {it.stream_byte, model_count_lo};
                sum          = {1'b0, model_credit} + {1'b0, count};
                model_phase  = PH_CMD;
                model_credit = (sum > {1'b0, rwsp_pkg::CREDIT_MAX}) ? rwsp_pkg::CREDIT_MAX :
                                                                      sum[15:0];
                ev.kind       = rwsp_pkg::KIND_WAIT;
                ev.wait_units = count[15:2];
                if (it.spare_empty && model_credit >= model_cost) begin
                    model_credit      = model_credit - model_cost;
                    ev.refill_request = 1'b1;
                end
                return 1'b1;
            end
        endcase
    endfunction

    // Drive one beat after a random gap; predict at the accepting edge.
    task automatic send_item(input rwsp_pkg::in_item_t it);
        int unsigned         gap;
        rwsp_pkg::out_item_t ev;
        gap = src_quiet ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (advance_player_model(it, ev))
            expected_events.push_back(ev);
    endtask

    // Drop valid and wait for every expected event plus the pipeline latency.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cost(input logic [15:0] cost);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= cost;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        model_cost = cost;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_write(input logic [4:0] addr, input logic [7:0] value);
        send_item(make_item({3'b000, addr}, 1'b0, 1'($urandom_range(0, 1))));
        send_item(make_item(value, 1'b0, 1'($urandom_range(0, 1))));
    endtask

    task automatic send_wait(input logic [15:0] count, input logic spare);
        send_item(make_item(rwsp_pkg::CMD_WAIT, 1'b0, 1'($urandom_range(0, 1))));
        send_item(make_item(count[7:0], 1'b0, 1'($urandom_range(0, 1))));
        send_item(make_item(count[15:8], 1'b0, spare));
    endtask

    function automatic logic [15:0] draw_count();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 5)
            return 16'($urandom_range(0, 255));
        if (pick < 10)
            return 16'(model_cost + $urandom_range(0, 8) - 4);
        if (pick < 16)
            return 16'($urandom_range(0, 65535));
        if (pick < 18)
            return rwsp_pkg::CREDIT_MAX;
        return 16'd0;
    endfunction

    function automatic logic [15:0] draw_cost();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return rwsp_pkg::REFILL_COST_RESET;
            3, 4, 5: return 16'($urandom_range(0, 2000));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic test_register_writes();
        send_write(5'd0, 8'h00);
        send_write(5'd31, 8'hFF);
        send_write(5'd16, 8'hA5);
    endtask

    task automatic test_waits_default_cost();
        send_wait(16'h0000, 1'b1);
        send_wait(rwsp_pkg::REFILL_COST_RESET - 16'd1, 1'b1);
        // credit now one below the cost: the next empty-spare wait, of count 1, refills
        send_wait(16'h0001, 1'b1);
        send_wait(16'hFFFF, 1'b0);
    endtask

    task automatic test_cost_extremes();
        write_cost(16'd0);
        send_wait(16'h0004, 1'b1);
        write_cost(16'hFFFF);
        send_wait(16'h0000, 1'b1);
    endtask

    task automatic test_random_traffic();
        int unsigned sent;
        int unsigned seg;
        for (seg = 0; seg < 8; seg++) begin
            if (seg == 0)
                write_cost(16'd0);
            else if (seg == 1)
                write_cost(16'hFFFF);
            else
                write_cost(draw_cost());
            src_quiet = ($urandom_range(0, 3) == 0);
            snk_quiet = ($urandom_range(0, 3) == 0);
            sent = 0;
            while (sent < 100) begin
                if ($urandom_range(0, 99) < 55) begin
                    send_write(5'($urandom_range(0, 31)),
                               ($urandom_range(0, 15) == 0) ? 8'hFF :
                                                              8'($urandom_range(0, 255)));
                    sent += 2;
                end else begin
                    send_wait(draw_count(), $urandom_range(0, 9) < 6);
                    sent += 3;
                end
            end
        end
        src_quiet = 1'b0;
        snk_quiet = 1'b0;
    endtask

    // Only one stop is possible per run; the seed picks which kind and where.
    task automatic test_stop_and_ignore();
        int unsigned lead;
        int unsigned how;
        logic [7:0]  b;
        lead = $urandom_range(0, 3);
        how  = $urandom_range(0, 2);
        if (how != 0)
            lead = 0;
        if (lead == 1)
            send_item(make_item(8'($urandom_range(0, 31)), 1'b0, 1'($urandom_range(0, 1))));
        if (lead >= 2)
            send_item(make_item(rwsp_pkg::CMD_WAIT, 1'b0, 1'($urandom_range(0, 1))));
        if (lead == 3)
            send_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1))));
        case (how)
            0: b = 8'($urandom_range(0, 255));
            1: b = rwsp_pkg::CMD_END;
            default: begin
                do b = 8'($urandom_range(rwsp_pkg::ADDR_LIMIT, 8'hFE));
                while (b == rwsp_pkg::CMD_WAIT);
            end
        endcase
        send_item(make_item(b, how == 0, 1'($urandom_range(0, 1))));
        // everything after the stop must drop out
        send_item(make_item(8'($urandom_range(0, 255)), 1'b1, 1'($urandom_range(0, 1))));
        repeat (12)
            send_item(make_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1))));
    endtask

    always @(posedge aclk) begin : check_results
        rwsp_pkg::out_item_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("unexpected event kind %0d", m_item.kind));
            end else begin
                want = expected_events.pop_front();
                if (m_item.kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d",
                                              m_item.kind, want.kind));
                if (m_item.reg_addr !== want.reg_addr)
                    report_mismatch($sformatf("reg_addr %0d, expected %0d",
                                              m_item.reg_addr, want.reg_addr));
                if (m_item.reg_value !== want.reg_value)
                    report_mismatch($sformatf("reg_value 0x%02h, expected 0x%02h",
                                              m_item.reg_value, want.reg_value));
                if (m_item.wait_units !== want.wait_units)
                    report_mismatch($sformatf("wait_units %0d, expected %0d",
                                              m_item.wait_units, want.wait_units));
                if (m_item.refill_request !== want.refill_request)
                    report_mismatch($sformatf("refill_request %0b, expected %0b",
                                              m_item.refill_request, want.refill_request));
            end
        end
    end

    initial begin : result_sink
        int unsigned stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = snk_quiet ? 0 : $urandom_range(0, 19);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid === 1'b1 && m_ready === 1'b1));
        end
    end

    initial begin
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_item    <= '0;
        model_phase    = PH_CMD;
        model_addr     = '0;
        model_count_lo = '0;
        model_credit   = '0;
        model_cost     = rwsp_pkg::REFILL_COST_RESET;
        model_halted   = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_register_writes();
        test_waits_default_cost();
        test_cost_extremes();
        test_random_traffic();
        test_stop_and_ignore();

        wait_idle();
        repeat (8) @(posedge aclk);
        if (expected_events.size() != 0)
            report_mismatch($sformatf("%0d expected events never arrived",
                                      expected_events.size()));
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
